// ===== hw/rtl/button_press_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// button press classifier assertion macros
// assertion shorthands for the checker file bpc_checker.sv
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define BPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bpc assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define BPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bpc assertion failed");

`endif

// ===== hw/rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// types, codes and helper functions of the button press classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    // counter width of the stable and hold counters
    localparam int COUNT_WIDTH = 16;
    // width of each configuration register
    localparam int CFG_WIDTH   = 16;
    // width of the press duration field
    localparam int TICKS_WIDTH = 16;
    // common compare width of counters and registers
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;
    typedef logic [CFG_WIDTH-1:0]   t_cfg_val;
    typedef logic [CMP_WIDTH-1:0]   t_cmp;

    localparam t_cnt CNT_MAX = {COUNT_WIDTH{1'b1}};

    // register indexes
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] CFG_MIN_SHORT  = 2'd1;
    localparam logic [1:0] CFG_WARN       = 2'd2;
    localparam logic [1:0] CFG_FACTORY    = 2'd3;

    // register reset values
    localparam t_cfg_val CFG_DEBOUNCE_RST  = 16'd50;
    localparam t_cfg_val CFG_MIN_SHORT_RST = 16'd100;
    localparam t_cfg_val CFG_WARN_RST      = 16'd1500;
    localparam t_cfg_val CFG_FACTORY_RST   = 16'd3000;

    // link modes
    localparam logic [1:0] MODE_BLE = 2'd1;

    // event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PRESS   = 3'd1;
    localparam logic [2:0] EV_WARN    = 3'd2;
    localparam logic [2:0] EV_FACTORY = 3'd3;
    localparam logic [2:0] EV_CANCEL  = 3'd4;
    localparam logic [2:0] EV_TO_WIFI = 3'd5;
    localparam logic [2:0] EV_TO_BLE  = 3'd6;

    typedef struct packed {
        logic       key_level;
        logic [1:0] current_mode;
        logic       switch_done;
    } t_in_word;

    typedef struct packed {
        logic [2:0]             event_code;
        logic [TICKS_WIDTH-1:0] press_ticks;
    } t_out_word;

    typedef struct packed {
        t_cfg_val debounce_ticks;
        t_cfg_val min_short_ticks;
        t_cfg_val warn_ticks;
        t_cfg_val factory_reset_ticks;
    } t_cfg;

    // debouncer view of the current tick
    typedef struct packed {
        logic settled;
        logic level;
    } t_deb_status;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic t_cmp cnt_to_cmp(input t_cnt v);
        return t_cmp'(v);
    endfunction

    function automatic t_cmp cfg_to_cmp(input t_cfg_val v);
        return t_cmp'(v);
    endfunction

    // press duration clipped to the field width
    function automatic logic [TICKS_WIDTH-1:0] sat_ticks(input t_cnt v);
        if (cnt_to_cmp(v) > t_cmp'({TICKS_WIDTH{1'b1}})) begin
            return {TICKS_WIDTH{1'b1}};
        end
        return TICKS_WIDTH'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bpc_debounce.sv =====
// ----------------------------------------------------------------------------
// bpc_debounce
// tracks the last key level and how long it has been stable
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_debounce import bpc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic        i_level,
    input  wire t_cfg_val    i_debounce_ticks,
    output t_deb_status      o_status
);

    logic r_last_level;
    logic n_last_level;
    t_cnt r_stable_count;
    t_cnt n_stable_count;
    t_cnt stable_inc;
    logic changed;

    assign changed    = (i_level != r_last_level);
    assign stable_inc = sat_inc(r_stable_count);

    always_comb begin
        if (changed) begin
            n_last_level   = i_level;
            n_stable_count = '0;
        end else begin
            n_last_level   = r_last_level;
            n_stable_count = stable_inc;
        end
    end

    assign o_status.level   = i_level;
    assign o_status.settled = !changed &&
                              (cnt_to_cmp(stable_inc) > cfg_to_cmp(i_debounce_ticks));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= 1'b1;
            r_stable_count <= '0;
        end else if (i_step) begin
            r_last_level   <= n_last_level;
            r_stable_count <= n_stable_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_press_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpc_press_ctrl
// press timing, busy tracking and event selection for one tick
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_press_ctrl import bpc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire t_in_word    i_word,
    input  wire t_deb_status i_deb,
    input  wire t_cfg        i_cfg,
    output t_out_word        o_result
);

    logic       r_seen_released;
    logic       n_seen_released;
    logic       r_press_active;
    logic       n_press_active;
    t_cnt       r_hold_count;
    t_cnt       n_hold_count;
    logic       r_long_pending;
    logic       n_long_pending;
    logic       r_switch_busy;
    logic       n_switch_busy;
    logic       r_reset_latched;
    logic       n_reset_latched;
    logic       busy_now;
    t_cnt       hold_now;
    t_cmp       hold_cmp;
    logic [2:0] event_code;

    // switch_done clears busy before the tick is looked at
    assign busy_now = r_switch_busy & ~i_word.switch_done;
    assign hold_now = r_press_active ? sat_inc(r_hold_count) : r_hold_count;
    assign hold_cmp = cnt_to_cmp(hold_now);

    always_comb begin
        n_seen_released = r_seen_released | i_word.key_level;
        n_press_active  = r_press_active;
        n_hold_count    = hold_now;
        n_long_pending  = r_long_pending;
        n_switch_busy   = busy_now;
        n_reset_latched = r_reset_latched;
        event_code      = EV_NONE;
        if (i_deb.settled) begin
            if (!i_deb.level) begin
                if (r_seen_released && !busy_now) begin
                    if (!r_press_active) begin
                        n_press_active = 1'b1;
                        n_hold_count   = '0;
                        n_long_pending = 1'b0;
                        event_code     = EV_PRESS;
                    end else begin
                        if (hold_cmp >= cfg_to_cmp(i_cfg.warn_ticks) && !r_long_pending) begin
                            n_long_pending = 1'b1;
                            event_code     = EV_WARN;
                        end
                        if (hold_cmp >= cfg_to_cmp(i_cfg.factory_reset_ticks) &&
                            !r_reset_latched) begin
                            n_reset_latched = 1'b1;
                            event_code      = EV_FACTORY;
                        end
                    end
                end
            end else if (r_press_active) begin
                n_press_active = 1'b0;
                if (r_long_pending) begin
                    n_long_pending = 1'b0;
                    event_code     = EV_CANCEL;
                end else if (hold_cmp >= cfg_to_cmp(i_cfg.min_short_ticks) &&
                             hold_cmp < cfg_to_cmp(i_cfg.warn_ticks) && !busy_now) begin
                    n_switch_busy = 1'b1;
                    event_code    = (i_word.current_mode == MODE_BLE) ? EV_TO_WIFI : EV_TO_BLE;
                end
            end
        end
    end

    assign o_result.event_code  = event_code;
    assign o_result.press_ticks = sat_ticks(n_hold_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_released <= 1'b0;
            r_press_active  <= 1'b0;
            r_hold_count    <= '0;
            r_long_pending  <= 1'b0;
            r_switch_busy   <= 1'b0;
            r_reset_latched <= 1'b0;
        end else if (i_step) begin
            r_seen_released <= n_seen_released;
            r_press_active  <= n_press_active;
            r_hold_count    <= n_hold_count;
            r_long_pending  <= n_long_pending;
            r_switch_busy   <= n_switch_busy;
            r_reset_latched <= n_reset_latched;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_classifier
// debounces a key sampled once per tick and classifies presses into events
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                 word
// -------  ---------  ------------------------  ------------------------------
// in       input      i_in_valid / o_in_stall   i_in_word  (t_in_word)
// out      output     o_out_valid / i_out_stall o_out_word (t_out_word)
// cfg      input      i_cfg_we, no handshake    i_cfg_index, i_cfg_data
//
// one tick word per cycle sustained while i_out_stall is low; each word gives exactly one result word
// a word passes through the input register, then the result register
// the per-tick state update happens when a word moves into the result register
// i_out_stall holds the result register; the input register stalls only when
// it is full and the result register is held
// reset (i_rst_n low, synchronous) empties both registers, clears the
// classifier state and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier import bpc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // tick channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_word   i_in_word,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_word       o_out_word,
    // register writes
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire t_cfg_val   i_cfg_data
);

    // configuration registers
    t_cfg        r_cfg;

    // input register
    logic        r_in_valid;
    t_in_word    r_in_word;

    // result register
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        step;       // word in the input register moves to the result register
    logic        in_take;    // new tick word accepted
    t_deb_status deb_status;
    t_out_word   result;

    // the result register frees up when empty or being drained
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    // register writes, to be made only while idle; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= CFG_DEBOUNCE_RST;
            r_cfg.min_short_ticks     <= CFG_MIN_SHORT_RST;
            r_cfg.warn_ticks          <= CFG_WARN_RST;
            r_cfg.factory_reset_ticks <= CFG_FACTORY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:  r_cfg.debounce_ticks      <= i_cfg_data;
                CFG_MIN_SHORT: r_cfg.min_short_ticks     <= i_cfg_data;
                CFG_WARN:      r_cfg.warn_ticks          <= i_cfg_data;
                CFG_FACTORY:   r_cfg.factory_reset_ticks <= i_cfg_data;
                default:       r_cfg                     <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // level tracking and debounce
    bpc_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_level          (r_in_word.key_level),
        .i_debounce_ticks (r_cfg.debounce_ticks),
        .o_status         (deb_status)
    );

    // press timing and event selection
    bpc_press_ctrl u_press_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .i_deb    (deb_status),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// bpc_checker
// port-level checks of the button press classifier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_macros.svh"

module bpc_checker import bpc_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire t_out_word  o_out_word
);

    // a held result word stays put
    `BPC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

    // input side backs up only behind a held result
    `BPC_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // no event code beyond the defined set
    `BPC_ASSERT_NOW(a_code_range, o_out_valid, o_out_word.event_code <= EV_TO_BLE)

    // a press starts its timer from zero
    `BPC_ASSERT_NOW(a_press_zero, o_out_valid && (o_out_word.event_code == EV_PRESS),
        o_out_word.press_ticks == '0)

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the button press classifier: a directed table of
// key ticks, then random presses and noise over several register settings, and
// results checked against table rows or an in-bench model of debouncer and classifier
// ----------------------------------------------------------------------------

module tb_top;
    import bpc_pkg::*;

    // consecutive cycles with no handshake before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;
    // printed mismatch lines are capped, all of them are counted
    localparam int MAX_PRINTED    = 30;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = CFG_DEBOUNCE;
    t_cfg_val   i_cfg_data  = '0;

    button_press_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // classifier model: own copy of registers and per-tick state
    // ------------------------------------------------------------------
    t_cfg_val deb_lim   = CFG_DEBOUNCE_RST;
    t_cfg_val short_min = CFG_MIN_SHORT_RST;
    t_cfg_val warn_lim  = CFG_WARN_RST;
    t_cfg_val fr_lim    = CFG_FACTORY_RST;

    logic lvl_q      = 1'b1;   // last key level seen, starts released
    logic seen_rel   = 1'b0;   // key has been released at least once
    t_cnt settle_cnt = '0;     // ticks the level has been stable
    logic pressing   = 1'b0;
    t_cnt hold_cnt   = '0;
    logic warned     = 1'b0;   // long press pending, release gives cancel
    logic busy       = 1'b0;   // link switch in progress
    logic fr_latched = 1'b0;   // factory reset reported once per reset

    // advance the model by one tick and return the result word it gives
    function automatic t_out_word classify_tick(input t_in_word w);
        logic [2:0] ev;
        t_out_word  r;
        ev = EV_NONE;
        // done flag acts before anything else on this tick
        if (w.switch_done) begin
            busy = 1'b0;
        end
        // hold time runs through bounces and busy time alike
        if (pressing && hold_cnt != CNT_MAX) begin
            hold_cnt = hold_cnt + 1'b1;
        end
        if (w.key_level) begin
            seen_rel = 1'b1;
        end
        if (w.key_level != lvl_q) begin
            // level change only restarts the debounce count
            lvl_q      = w.key_level;
            settle_cnt = '0;
        end else begin
            if (settle_cnt != CNT_MAX) begin
                settle_cnt = settle_cnt + 1'b1;
            end
            if (settle_cnt > deb_lim) begin
                if (!w.key_level) begin
                    if (!seen_rel) begin
                        // stuck low since reset: ignored
                        ev = EV_NONE;
                    end else if (!pressing && !busy) begin
                        pressing = 1'b1;
                        hold_cnt = '0;
                        warned   = 1'b0;
                        ev       = EV_PRESS;
                    end else if (pressing && !busy) begin
                        if (hold_cnt >= warn_lim && !warned) begin
                            warned = 1'b1;
                            ev     = EV_WARN;
                        end
                        // factory reset wins when both thresholds hit together
                        if (hold_cnt >= fr_lim && !fr_latched) begin
                            fr_latched = 1'b1;
                            ev         = EV_FACTORY;
                        end
                    end
                end else if (pressing) begin
                    pressing = 1'b0;
                    if (warned) begin
                        warned = 1'b0;
                        ev     = EV_CANCEL;
                    end else if (hold_cnt >= short_min && hold_cnt < warn_lim && !busy) begin
                        busy = 1'b1;
                        ev   = (w.current_mode == MODE_BLE) ? EV_TO_WIFI : EV_TO_BLE;
                    end
                end
            end
        end
        r.event_code  = ev;
        r.press_ticks = hold_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    t_out_word pending_results[$];
    int        err_cnt = 0;
    int        ev_tally[7];
    int        ticks_sent = 0;
    int        settings_used = 0;

    task automatic report_mismatch(input string what, input t_out_word got,
                                   input t_out_word want);
        if (err_cnt < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s got ev=%0d ticks=%0d want ev=%0d ticks=%0d",
                     $realtime, what, got.event_code, got.press_ticks,
                     want.event_code, want.press_ticks);
        end
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", o_out_word, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.event_code != want.event_code) begin
                    report_mismatch("event code", o_out_word, want);
                end
                if (o_out_word.press_ticks != want.press_ticks) begin
                    report_mismatch("press ticks", o_out_word, want);
                end
                if (want.event_code <= EV_TO_BLE) begin
                    ev_tally[want.event_code]++;
                end
            end
        end
    end

    // watchdog: any handshake or register write keeps it quiet
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("button_press_classifier verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // idling on both sides
    // ------------------------------------------------------------------
    bit calm = 1'b0;   // no gaps and no stalls while set

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure in runs
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // tick driver and register writes
    // ------------------------------------------------------------------

    // drive one tick word; valid stays high across back-to-back words
    task automatic send_tick(input t_in_word w, input bit typed, input t_out_word want);
        int        gap;
        t_out_word pred;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // word accepted at this edge
        pred = classify_tick(w);
        pending_results.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input t_cfg_val val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_DEBOUNCE:  deb_lim   = val;
            CFG_MIN_SHORT: short_min = val;
            CFG_WARN:      warn_lim  = val;
            CFG_FACTORY:   fr_lim    = val;
            default: ;
        endcase
    endtask

    // registers change only with the block drained
    task automatic load_setting(input t_cfg_val d, input t_cfg_val m,
                                input t_cfg_val w, input t_cfg_val f);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        cfg_write(CFG_DEBOUNCE, d);
        cfg_write(CFG_MIN_SHORT, m);
        cfg_write(CFG_WARN, w);
        cfg_write(CFG_FACTORY, f);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------

    // a full press: debounced low of chosen length, then a debounced release;
    // hold time at the release tick equals the low length when nothing bounces
    task automatic play_press();
        int         tgt;
        int         low_len;
        int         high_len;
        logic [1:0] md;
        t_in_word   t;
        md = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       tgt = $urandom_range(0, int'(short_min));
            1:       tgt = $urandom_range(int'(short_min), int'(warn_lim));
            2:       tgt = int'(warn_lim) + $urandom_range(0, 3);
            default: tgt = int'(fr_lim) + $urandom_range(0, 3);
        endcase
        low_len  = (tgt > int'(deb_lim) + 2) ? tgt : int'(deb_lim) + 2;
        high_len = int'(deb_lim) + 2 + $urandom_range(0, 3);
        // huge settings would never finish a press, keep them bounded
        if (low_len > 150) low_len = $urandom_range(100, 150);
        if (high_len > 150) high_len = $urandom_range(100, 150);
        for (int k = 0; k < low_len; k++) begin
            t.key_level    = ($urandom_range(0, 39) == 0);
            t.current_mode = md;
            t.switch_done  = ($urandom_range(0, 24) == 0);
            send_tick(t, 1'b0, '0);
        end
        for (int k = 0; k < high_len; k++) begin
            t.key_level    = ($urandom_range(0, 39) != 0);
            t.current_mode = md;
            t.switch_done  = (k == 0) ? ($urandom_range(0, 1) == 1)
                                      : ($urandom_range(0, 24) == 0);
            send_tick(t, 1'b0, '0);
        end
    endtask

    // a burst of unrelated ticks
    task automatic play_noise();
        int       n;
        t_in_word t;
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
            t = t_in_word'($urandom_range(0, 15));
            send_tick(t, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input t_cfg_val d, input t_cfg_val m, input t_cfg_val w,
                             input t_cfg_val f, input int n, input bit calm_in);
        int first;
        load_setting(d, m, w, f);
        calm  = calm_in;
        first = ticks_sent;
        while (ticks_sent - first < n) begin
            if ($urandom_range(0, 4) == 0) begin
                play_noise();
            end else begin
                play_press();
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef struct {
        t_in_word  word;
        bit        typed;   // expected result written in the row
        t_out_word want;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic void row(input logic lvl, input logic [1:0] md, input logic dn,
                                input bit typed, input logic [2:0] ev, input int tk);
        t_dir_row r;
        r.word.key_level    = lvl;
        r.word.current_mode = md;
        r.word.switch_done  = dn;
        r.typed             = typed;
        r.want.event_code   = ev;
        r.want.press_ticks  = tk[TICKS_WIDTH-1:0];
        dir_rows.push_back(r);
    endfunction

    initial begin
        // settings for the table: no debounce, short from 1, warn and
        // factory reset both at 3 so they land on the same tick
        // key low straight out of reset, then stuck low: both ignored
        row(1'b0, 2'd0, 1'b0, 1'b1, EV_NONE,    0);
        row(1'b0, 2'd2, 1'b0, 1'b1, EV_NONE,    0);
        // first release arms the classifier
        row(1'b1, 2'd0, 1'b0, 1'b1, EV_NONE,    0);
        row(1'b1, 2'd0, 1'b0, 1'b1, EV_NONE,    0);
        // long hold: warn and factory reset on one tick, then cancel
        row(1'b0, 2'd0, 1'b0, 1'b1, EV_NONE,    0);
        row(1'b0, 2'd0, 1'b0, 1'b1, EV_PRESS,   0);
        row(1'b0, 2'd0, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b0, 2'd0, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b0, 2'd0, 1'b0, 1'b1, EV_FACTORY, 3);
        row(1'b1, 2'd0, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b1, 2'd0, 1'b0, 1'b1, EV_CANCEL,  5);
        // short press in BLE mode asks for WiFi and sets busy
        row(1'b0, 2'd1, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b0, 2'd1, 1'b0, 1'b1, EV_PRESS,   0);
        row(1'b1, 2'd1, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b1, 2'd1, 1'b0, 1'b1, EV_TO_WIFI, 2);
        // press while busy starts nothing
        row(1'b0, 2'd1, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b0, 2'd1, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b1, 2'd3, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b1, 2'd3, 1'b0, 1'b0, EV_NONE,    0);
        // done clears busy; unknown mode asks for BLE
        row(1'b0, 2'd3, 1'b1, 1'b0, EV_NONE,    0);
        row(1'b0, 2'd3, 1'b0, 1'b1, EV_PRESS,   0);
        row(1'b1, 2'd3, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b1, 2'd3, 1'b0, 1'b1, EV_TO_BLE,  2);
        // mode none also asks for BLE
        row(1'b0, 2'd0, 1'b1, 1'b0, EV_NONE,    0);
        row(1'b0, 2'd0, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b1, 2'd0, 1'b0, 1'b0, EV_NONE,    0);
        row(1'b1, 2'd0, 1'b0, 1'b0, EV_NONE,    0);
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_setting(16'd0, 16'd1, 16'd3, 16'd3);
        for (int r = 0; r < dir_rows.size(); r++) begin
            send_tick(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);
        end

        // random phases; all-zero and all-ones registers among them
        run_phase(16'd2,  16'd3,  16'd8,  16'd14, 300, 1'b0);
        run_phase(16'd0,  16'd0,  16'd0,  16'd0,  200, 1'b1);
        run_phase(16'd1,  16'd4,  16'd10, 16'd6,  250, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 1'b0);
        run_phase(t_cfg_val'($urandom_range(0, 4)),  t_cfg_val'($urandom_range(0, 6)),
                  t_cfg_val'($urandom_range(0, 20)), t_cfg_val'($urandom_range(0, 30)),
                  300, 1'b0);
        run_phase(16'd5,  16'd10, 16'd40, 16'd80, 400, 1'b0);

        // drain, then let the pipeline settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("ran %0d key ticks over %0d register settings", ticks_sent, settings_used);
        $display("events: press %0d warn %0d factory %0d cancel %0d wifi %0d ble %0d",
                 ev_tally[EV_PRESS], ev_tally[EV_WARN], ev_tally[EV_FACTORY],
                 ev_tally[EV_CANCEL], ev_tally[EV_TO_WIFI], ev_tally[EV_TO_BLE]);
        if (err_cnt == 0) begin
            $display("button_press_classifier verification clean");
        end else begin
            $display("button_press_classifier verification failed");
        end
        $finish;
    end

endmodule
